// File: hdl/bfg_pkg.sv
// Package for the 8-bit grayscale bilateral filter.
// Holds the item kinds, register indexes, controller states and default sizes.
// No dependencies.
package bfg_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_MAX_RADIUS  = 7;
    localparam int DEF_WEIGHT_BITS = 16;

    // Largest radius any build supports
    localparam int RADIUS_LIMIT = 7;

    typedef enum logic [1:0] {
        KIND_COLOR   = 2'd0,
        KIND_SPATIAL = 2'd1,
        KIND_PIXEL   = 2'd2,
        KIND_REQUEST = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// File: hdl/bilateral_filter_gray8.sv
// Bilateral filter on an 8-bit grayscale frame, fixed point.
// Frame store and both weight tables are block memories inside this module.
// Depends on bfg_pkg.
//
// Usage:
//   Input beats (s_*) load a color weight, load a spatial weight, write a
//   frame pixel, or request one filtered pixel. Only a request produces an
//   output beat (m_*), carrying the filtered value, the echoed position and
//   an outside_frame flag.
//   Loads and pixel writes are taken only while the block is idle.
//   A request inside the frame passes from acceptance to the output beat
//   through one centre read, a scan of one window position per cycle
//   through a four-stage read / weight / accumulate pipeline on the frame
//   memory port, a drain of that pipeline, an eight-step restoring divider
//   and the load of the output register.
//   A request outside the frame goes straight to the output state.
//   The output beat sits in a register: loads and writes are still taken
//   while it waits; a new request waits in the output state until the
//   register is free.
//   Reset sets width and height to 256 and radius to 3. Memory contents are
//   not cleared and must be written before they are read. The user must write
//   configuration on the APB port only while the block is idle (not enforced).
module bilateral_filter_gray8
    import bfg_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_table_index,
    input  logic [15:0] s_value,
    input  logic [7:0]  s_pos_x,
    input  logic [7:0]  s_pos_y,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_filtered,
    output logic [7:0]  m_res_x,
    output logic [7:0]  m_res_y,
    output logic        m_outside_frame
);

    localparam int FW     = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int FH     = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
    localparam int RMAX   = (MAX_RADIUS < RADIUS_LIMIT) ? MAX_RADIUS : RADIUS_LIMIT;
    localparam int FDEPTH = FW * FH;
    localparam int ADDR_W = $clog2(FDEPTH);
    localparam int WB     = WEIGHT_BITS;
    localparam int TOT_W  = WB + 8;
    localparam int SUM_W  = WB + 16;
    localparam int NUM_W  = SUM_W + 1;
    localparam int DSH_W  = TOT_W + 7;

    localparam logic [ADDR_W-1:0] FW_A = ADDR_W'(FW);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [8:0] width_reg, height_reg;
    logic [2:0] radius_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            radius_reg <= 3'd3;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_WIDTH:  width_reg  <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[8:0];
                REG_RADIUS: radius_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Read back the raw register values
    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_WIDTH:  prdata = {23'd0, width_reg};
            REG_HEIGHT: prdata = {23'd0, height_reg};
            REG_RADIUS: prdata = {29'd0, radius_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // Saturate the registers to the supported range, raising zero to one
    logic [8:0] w_eff, h_eff;
    logic [2:0] r_eff;
    logic [3:0] kw_last;

    always_comb begin
        w_eff = (width_reg == 9'd0) ? 9'd1 :
                (width_reg > 9'(FW)) ? 9'(FW) : width_reg;
        h_eff = (height_reg == 9'd0) ? 9'd1 :
                (height_reg > 9'(FH)) ? 9'(FH) : height_reg;
        r_eff = (radius_reg == 3'd0) ? 3'd1 :
                (radius_reg > 3'(RMAX)) ? 3'(RMAX) : radius_reg;
        kw_last = {r_eff, 1'b0};
    end

    // ---------------------------------------------------------------
    // Controller
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    logic       in_acc, req_acc, req_inside;
    logic [3:0] iy_reg, ix_reg;
    logic [7:0] widx_reg;
    logic       scan_last;
    logic       a_v_reg, b_v_reg, c_v_reg;
    logic [2:0] step_reg;
    logic       m_valid_reg;

    assign in_acc     = s_valid & s_ready;
    assign req_acc    = in_acc & (kind_t'(s_kind) == KIND_REQUEST);
    assign req_inside = ({1'b0, s_pos_x} < w_eff) & ({1'b0, s_pos_y} < h_eff);
    assign scan_last  = (iy_reg == kw_last) & (ix_reg == kw_last);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_acc) begin
                    state_next = req_inside ? ST_CENTRE : ST_OUT;
                end
            end
            ST_CENTRE: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!a_v_reg && !b_v_reg && !c_v_reg) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_reg == 3'd7) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    logic s_ready_c, issue_c, div_load_c, div_step_c, out_load_c;

    always_comb begin
        s_ready_c  = 1'b0;
        issue_c    = 1'b0;
        div_load_c = 1'b0;
        div_step_c = 1'b0;
        out_load_c = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready_c  = 1'b1;
            ST_CENTRE: ;
            ST_SCAN:   issue_c    = 1'b1;
            ST_DRAIN:  div_load_c = !a_v_reg && !b_v_reg && !c_v_reg;
            ST_DIV:    div_step_c = 1'b1;
            ST_OUT:    out_load_c = !m_valid_reg;
            default: ;
        endcase
    end

    assign s_ready = s_ready_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // Request registers
    // ---------------------------------------------------------------
    logic [7:0] req_x_reg, req_y_reg;
    logic       req_out_reg;
    logic [7:0] centre_reg;

    always_ff @(posedge aclk) begin
        if (req_acc) begin
            req_x_reg   <= s_pos_x;
            req_y_reg   <= s_pos_y;
            req_out_reg <= !req_inside;
        end
    end

    // ---------------------------------------------------------------
    // Window address generation
    // ---------------------------------------------------------------
    logic signed [10:0] ty, tx;
    logic               win_in;
    logic [ADDR_W-1:0]  win_addr;

    always_comb begin
        ty = $signed({3'd0, req_y_reg}) + $signed({7'd0, iy_reg}) - $signed({8'd0, r_eff});
        tx = $signed({3'd0, req_x_reg}) + $signed({7'd0, ix_reg}) - $signed({8'd0, r_eff});
        win_in = !ty[10] && (ty[9:0] < {1'b0, h_eff}) &&
                 !tx[10] && (tx[9:0] < {1'b0, w_eff});
        win_addr = ADDR_W'(ty[7:0]) * FW_A + ADDR_W'(tx[7:0]);
    end

    // Step the window counters
    always_ff @(posedge aclk) begin
        if (req_acc) begin
            iy_reg   <= 4'd0;
            ix_reg   <= 4'd0;
            widx_reg <= 8'd0;
        end else if (issue_c) begin
            widx_reg <= widx_reg + 8'd1;
            if (ix_reg == kw_last) begin
                ix_reg <= 4'd0;
                iy_reg <= iy_reg + 4'd1;
            end else begin
                ix_reg <= ix_reg + 4'd1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic [7:0]    frame_mem [FDEPTH];
    logic [WB-1:0] spat_mem  [256];
    logic [WB-1:0] col_mem   [256];

    logic [ADDR_W-1:0] fr_raddr, fr_waddr;
    logic              fr_we;
    logic [7:0]        fr_rdata;
    logic [WB-1:0]     sp_rdata, col_rdata;
    logic [WB-1:0]     wval;
    logic [7:0]        col_raddr;

    assign wval     = WB'(s_value);
    assign fr_waddr = ADDR_W'(s_pos_y) * FW_A + ADDR_W'(s_pos_x);
    assign fr_we    = in_acc && (kind_t'(s_kind) == KIND_PIXEL) &&
                      ({1'b0, s_pos_x} < 9'(FW)) && ({1'b0, s_pos_y} < 9'(FH));
    // Centre read while idle, window reads while scanning
    assign fr_raddr = issue_c ? win_addr : fr_waddr;

    always_ff @(posedge aclk) begin
        if (fr_we) begin
            frame_mem[fr_waddr] <= s_value[7:0];
        end
        fr_rdata <= frame_mem[fr_raddr];
    end

    always_ff @(posedge aclk) begin
        if (in_acc && (kind_t'(s_kind) == KIND_SPATIAL)) begin
            spat_mem[s_table_index] <= wval;
        end
        sp_rdata <= spat_mem[widx_reg];
    end

    always_ff @(posedge aclk) begin
        if (in_acc && (kind_t'(s_kind) == KIND_COLOR)) begin
            col_mem[s_table_index] <= wval;
        end
        col_rdata <= col_mem[col_raddr];
    end

    // ---------------------------------------------------------------
    // Weight pipeline: read, color lookup, weight, accumulate
    // ---------------------------------------------------------------
    logic [7:0]      b_nval_reg, c_nval_reg;
    logic [WB-1:0]   b_sp_reg, c_wt_reg;
    logic [2*WB-1:0] prod;
    logic [SUM_W-1:0] sum_reg;
    logic [TOT_W-1:0] total_reg;

    assign col_raddr = (fr_rdata > centre_reg) ? (fr_rdata - centre_reg)
                                               : (centre_reg - fr_rdata);
    assign prod = b_sp_reg * col_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end else begin
            a_v_reg <= issue_c & win_in;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CENTRE) begin
            centre_reg <= fr_rdata;
        end
        b_nval_reg <= fr_rdata;
        b_sp_reg   <= sp_rdata;
        c_nval_reg <= b_nval_reg;
        c_wt_reg   <= prod[2*WB-1:WB];
    end

    // Accumulate weighted sum and total weight
    always_ff @(posedge aclk) begin
        if (req_acc) begin
            sum_reg   <= '0;
            total_reg <= '0;
        end else if (c_v_reg) begin
            sum_reg   <= sum_reg + SUM_W'(c_nval_reg) * SUM_W'(c_wt_reg);
            total_reg <= total_reg + TOT_W'(c_wt_reg);
        end
    end

    // ---------------------------------------------------------------
    // Restoring divider, one quotient bit per cycle
    // ---------------------------------------------------------------
    logic [NUM_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [7:0]       quo_reg;
    logic             fit;

    assign fit = rem_reg >= NUM_W'(dsh_reg);

    always_ff @(posedge aclk) begin
        if (div_load_c) begin
            rem_reg  <= NUM_W'(sum_reg) + NUM_W'(total_reg >> 1);
            dsh_reg  <= {total_reg, 7'd0};
            quo_reg  <= 8'd0;
            step_reg <= 3'd0;
        end else if (div_step_c) begin
            if (fit) begin
                rem_reg <= rem_reg - NUM_W'(dsh_reg);
            end
            quo_reg  <= {quo_reg[6:0], fit};
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg + 3'd1;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic [7:0] filt_reg, resx_reg, resy_reg;
    logic       outf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load_c) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load_c) begin
            resx_reg <= req_x_reg;
            resy_reg <= req_y_reg;
            outf_reg <= req_out_reg;
            if (req_out_reg) begin
                filt_reg <= 8'd0;
            end else if (total_reg == '0) begin
                filt_reg <= centre_reg;
            end else begin
                filt_reg <= quo_reg;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_filtered      = filt_reg;
    assign m_res_x         = resx_reg;
    assign m_res_y         = resy_reg;
    assign m_outside_frame = outf_reg;

endmodule

// File: hdl/bfg_chk.sv
// Port-level checker for bilateral_filter_gray8, bound to the top level.
// Depends on bfg_pkg.
module bfg_chk
    import bfg_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       pready,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_kind,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_filtered,
    input logic       m_outside_frame
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // Outside-frame results carry zero
    a_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outside_frame |-> m_filtered == 8'd0)
        else $error("outside-frame result is not zero");

    // Busy after taking a request
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (kind_t'(s_kind) == KIND_REQUEST) |=> !s_ready)
        else $error("input taken during a request");

    // Config port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind bilateral_filter_gray8 bfg_chk u_bfg_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .pready          (pready),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_kind          (s_kind),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_filtered      (m_filtered),
    .m_outside_frame (m_outside_frame)
);

// File: sim/bilateral_filter_gray8_test.sv
// Testbench for bilateral_filter_gray8: drives table loads, pixel writes and
// filter requests with random gaps and output stalls, predicts each filtered
// beat in-bench and compares it field by field. Depends on bfg_pkg and the RTL.
`timescale 1ns / 1ps

module bilateral_filter_gray8_test;
    import bfg_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int RAND_ITEMS   = 570;
    // side of the frame region that is always kept written
    localparam int REGION       = 16;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] tidx;
        logic [15:0] value;
        logic [7:0] px;
        logic [7:0] py;
    } beat_t;

    typedef struct packed {
        logic [7:0] filtered;
        logic [7:0] rx;
        logic [7:0] ry;
        logic       outside;
    } pix_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [7:0]  s_table_index = '0;
    logic [15:0] s_value = '0;
    logic [7:0]  s_pos_x = '0, s_pos_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_filtered, m_res_x, m_res_y;
    logic        m_outside_frame;

    bilateral_filter_gray8 uut (.*);

    always #6 aclk = ~aclk;

    // predictor state
    logic [7:0]  pix_mem [0:65535];
    logic [15:0] sp_w [0:255];
    logic [15:0] col_w [0:255];
    int unsigned cfg_w = 256, cfg_h = 256, cfg_r = 3;

    beat_t    pending_beats [$];
    pix_res_t expected_pix [$];
    int unsigned cycle_cnt = 0, mismatches = 0, results_seen = 0, requests_sent = 0;
    bit       quiet_gaps = 1'b0;

    function automatic pix_res_t filter_pixel(beat_t b);
        pix_res_t o;
        longint unsigned acc, tot, wt;
        int unsigned kw, ctr, nv, d;
        int nx, ny;
        o.rx = b.px; o.ry = b.py; o.outside = 1'b0; o.filtered = '0;
        if (b.px >= cfg_w || b.py >= cfg_h) begin
            o.outside = 1'b1;
            return o;
        end
        kw = 2 * cfg_r + 1;
        ctr = pix_mem[{b.py, b.px}];
        acc = 0; tot = 0;
        for (int iy = 0; iy < kw; iy++) begin
            ny = int'(b.py) + iy - int'(cfg_r);
            if (ny < 0 || ny >= cfg_h) continue;
            for (int ix = 0; ix < kw; ix++) begin
                nx = int'(b.px) + ix - int'(cfg_r);
                if (nx < 0 || nx >= cfg_w) continue;
                nv = pix_mem[ny * 256 + nx];
                d = nv > ctr ? nv - ctr : ctr - nv;
                wt = (longint'(sp_w[(iy * kw + ix) & 255]) * col_w[d]) >> 16;
                acc += nv * wt;
                tot += wt;
            end
        end
        if (tot == 0) o.filtered = ctr[7:0];
        else begin
            acc = (acc + tot / 2) / tot;
            o.filtered = acc > 255 ? 8'd255 : acc[7:0];
        end
        return o;
    endfunction

    // apply one accepted beat to the predictor
    task automatic absorb_beat(beat_t b);
        case (b.kind)
            KIND_COLOR:   col_w[b.tidx] = b.value;
            KIND_SPATIAL: sp_w[b.tidx] = b.value;
            KIND_PIXEL:   pix_mem[{b.py, b.px}] = b.value[7:0];
            default:      expected_pix.push_back(filter_pixel(b));
        endcase
    endtask

    // driver: present queued beats, holding back at random with a 10% chance unless quiet_gaps is set
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                absorb_beat(pending_beats.pop_front());
            end
            if ((!s_valid || s_ready)) begin
                if (pending_beats.size() > 0 &&
                    (quiet_gaps || $urandom_range(99) >= 10)) begin
                    s_valid <= 1'b1;
                    s_kind <= pending_beats[0].kind;
                    s_table_index <= pending_beats[0].tidx;
                    s_value <= pending_beats[0].value;
                    s_pos_x <= pending_beats[0].px;
                    s_pos_y <= pending_beats[0].py;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= quiet_gaps || $urandom_range(99) >= 10;
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            pix_res_t got, exp_r;
            got = '{m_filtered, m_res_x, m_res_y, m_outside_frame};
            results_seen <= results_seen + 1;
            if (expected_pix.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result beat %p", got);
            end else begin
                exp_r = expected_pix.pop_front();
                if (got !== exp_r) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch at (%0d,%0d): exp %p got %p",
                                 exp_r.rx, exp_r.ry, exp_r, got);
                end
            end
        end
    end

    // timeout
    always @(posedge aclk) begin
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_beat(kind_t k, int t, int v, int x, int y);
        beat_t b;
        b.kind = k; b.tidx = t[7:0]; b.value = v[15:0]; b.px = x[7:0]; b.py = y[7:0];
        if (k == KIND_REQUEST) requests_sent++;
        pending_beats.push_back(b);
    endtask

    // drain all traffic, then let an in-flight request settle
    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_valid || expected_pix.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic apb_write(reg_idx_t idx, int unsigned v);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_w = v > 256 ? 256 : (v == 0 ? 1 : v);
            REG_HEIGHT: cfg_h = v > 256 ? 256 : (v == 0 ? 1 : v);
            default:    cfg_r = v == 0 ? 1 : v;
        endcase
    endtask

    // fill both tables and the pixel region once so no unwritten entry is read
    task automatic fill_all();
        for (int i = 0; i < 256; i++) push_beat(KIND_COLOR, i, $urandom, 0, 0);
        for (int i = 0; i < 225; i++) push_beat(KIND_SPATIAL, i, $urandom, 0, 0);
        for (int y = 0; y < REGION; y++)
            for (int x = 0; x < REGION; x++)
                push_beat(KIND_PIXEL, 0, $urandom, x, y);
    endtask

    int unsigned fw, fh, rad, xmax, ymax;

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: small frame, extremes, zero weights, outside requests
        apb_write(REG_WIDTH, 8);
        apb_write(REG_HEIGHT, 6);
        apb_write(REG_RADIUS, 1);
        fill_all();
        push_beat(KIND_PIXEL, 0, 16'hFFFF, 0, 0);
        push_beat(KIND_PIXEL, 0, 16'h0000, 7, 5);
        push_beat(KIND_REQUEST, 0, 0, 0, 0);
        push_beat(KIND_REQUEST, 0, 0, 7, 5);
        push_beat(KIND_REQUEST, 0, 0, 8, 0);
        push_beat(KIND_REQUEST, 0, 0, 255, 255);
        push_beat(KIND_PIXEL, 0, 0, 255, 255);
        // clear the 3x3 spatial weights so the total weight is zero
        for (int i = 0; i < 9; i++) push_beat(KIND_SPATIAL, i, 0, 0, 0);
        push_beat(KIND_REQUEST, 0, 0, 3, 3);
        // full-scale weights
        for (int i = 0; i < 9; i++) push_beat(KIND_SPATIAL, i, 16'hFFFF, 0, 0);
        push_beat(KIND_COLOR, 0, 16'hFFFF, 0, 0);
        push_beat(KIND_COLOR, 255, 16'hFFFF, 0, 0);
        push_beat(KIND_REQUEST, 0, 0, 3, 3);
        push_beat(KIND_REQUEST, 0, 0, 1, 1);
        push_beat(KIND_REQUEST, 0, 0, 5, 4);
        wait_idle();

        // random phases over several frame shapes and radii
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin fw = 1; fh = 1; rad = 1; end
                1: begin fw = 256; fh = 256; rad = 7; end
                2: begin fw = 300; fh = 3; rad = 0; end
                default: begin
                    fw = $urandom_range(1, REGION);
                    fh = $urandom_range(1, REGION);
                    rad = $urandom_range(1, 7);
                end
            endcase
            apb_write(REG_WIDTH, fw);
            apb_write(REG_HEIGHT, fh);
            apb_write(REG_RADIUS, rad);
            quiet_gaps = (ph == 4);
            // in-frame requests keep their whole window inside the written region
            xmax = cfg_w <= REGION ? cfg_w - 1 : REGION - 1 - cfg_r;
            ymax = cfg_h <= REGION ? cfg_h - 1 : REGION - 1 - cfg_r;
            for (int n = 0; n < RAND_ITEMS / 6; n++) begin
                int unsigned x, y, rx, ry;
                x = $urandom_range(0, xmax);
                y = $urandom_range(0, ymax);
                case ($urandom_range(9))
                    0: push_beat(KIND_COLOR, $urandom, $urandom, $urandom, $urandom);
                    1: push_beat(KIND_SPATIAL, $urandom, $urandom, $urandom, $urandom);
                    2, 3: push_beat(KIND_PIXEL, $urandom, $urandom,
                                    $urandom_range(0, REGION - 1),
                                    $urandom_range(0, REGION - 1));
                    4: push_beat(KIND_PIXEL, $urandom, $urandom, $urandom, $urandom);
                    5: begin
                        rx = $urandom_range(255);
                        ry = $urandom_range(255);
                        // pull an in-frame request back into the written region
                        if (rx < cfg_w && ry < cfg_h && (rx > xmax || ry > ymax)) begin
                            rx = x;
                            ry = y;
                        end
                        push_beat(KIND_REQUEST, $urandom, $urandom, rx, ry);
                    end
                    default: push_beat(KIND_REQUEST, $urandom, $urandom, x, y);
                endcase
            end
            wait_idle();
        end

        $display("covered %0d requests and %0d result beats over a directed frame",
                 requests_sent, results_seen);
        $display("and six random frame shapes with loads and pixel writes mixed in");
        if (mismatches == 0 && expected_pix.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
